// ===== design/dle_pkg.sv =====
package dle_pkg;

    // Framing characters
    localparam logic [7:0] CH_DLE  = 8'h10;
    localparam logic [7:0] CH_SOH  = 8'h01;
    localparam logic [7:0] CH_STX  = 8'h02;
    localparam logic [7:0] CH_ETX  = 8'h03;
    localparam logic [7:0] CH_EOT  = 8'h04;
    localparam logic [7:0] CH_ENQ  = 8'h05;
    localparam logic [7:0] CH_ACK0 = 8'h06;
    localparam logic [7:0] CH_ACK1 = 8'h08;
    localparam logic [7:0] CH_ETB  = 8'h17;

    // Receive block size and index width (index must reach BLOCK_BYTES)
    localparam int BLOCK_BYTES = 1024;
    localparam int IDX_W       = $clog2(BLOCK_BYTES + 1);

    localparam int POS_W = 10;

    // Command queue depth
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Input function codes
    localparam logic [1:0] FUNC_RX      = 2'd0;
    localparam logic [1:0] FUNC_TX_DATA = 2'd1;
    localparam logic [1:0] FUNC_TX_CTRL = 2'd2;

    // Result kinds
    localparam logic [1:0] KIND_LINE = 2'd0;
    localparam logic [1:0] KIND_DATA = 2'd1;
    localparam logic [1:0] KIND_CTRL = 2'd2;

    // Back-end operations
    typedef enum logic [2:0] {
        OP_DATA       = 3'd0,  // received data byte
        OP_CTRL       = 3'd1,  // received control event
        OP_CTRL_REPLY = 3'd2,  // control event plus DLE, reply on line
        OP_TX1        = 3'd3,  // line byte
        OP_TX2        = 3'd4,  // DLE, line byte
        OP_TX3        = 3'd5   // DLE, DLE, line byte
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [7:0]         value;
        logic [POS_W-1:0]   position;
        logic               overflow;
    } t_cmd;

    function automatic logic [7:0] reply_code(input logic [7:0] code);
        logic [7:0] r;
        r = 8'h00;
        case (code)
            CH_ENQ:  r = CH_ACK0;
            CH_ETB:  r = CH_ACK1;
            CH_ETX:  r = CH_EOT;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

// ===== design/dle_front.sv =====
module dle_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic              i_cfg_wr_data,
    input  logic              i_valid,
    input  logic [1:0]        i_func,
    input  logic [7:0]        i_byte_value,
    input  logic              i_q_full,
    output logic              o_ready,
    output logic              o_push,
    output dle_pkg::t_cmd     o_cmd
);

    logic                      r_auto_reply;
    logic                      r_escape;
    logic                      n_escape;
    logic [dle_pkg::IDX_W-1:0] r_index;
    logic [dle_pkg::IDX_W-1:0] n_index;
    logic                      accept;
    logic                      is_dle;
    logic                      has_reply;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;
    assign is_dle  = (i_byte_value == dle_pkg::CH_DLE);
    assign has_reply = r_auto_reply && (dle_pkg::reply_code(i_byte_value) != 8'h00);

    always_comb begin
        n_escape       = r_escape;
        n_index        = r_index;
        o_push         = 1'b0;
        o_cmd.op       = dle_pkg::OP_TX1;
        o_cmd.value    = i_byte_value;
        o_cmd.position = '0;
        o_cmd.overflow = 1'b0;
        case (i_func)
            dle_pkg::FUNC_RX: begin
                if (!r_escape && is_dle) begin
                    n_escape = 1'b1;
                end else if (is_dle || !r_escape) begin
                    // plain data or doubled DLE
                    n_escape = 1'b0;
                    o_push   = 1'b1;
                    o_cmd.op = dle_pkg::OP_DATA;
                    if (r_index < dle_pkg::IDX_W'(dle_pkg::BLOCK_BYTES)) begin
                        o_cmd.position = dle_pkg::POS_W'(r_index);
                        n_index        = r_index + 1'b1;
                    end else begin
                        o_cmd.overflow = 1'b1;
                    end
                end else begin
                    n_escape = 1'b0;
                    o_push   = 1'b1;
                    o_cmd.op = has_reply ? dle_pkg::OP_CTRL_REPLY : dle_pkg::OP_CTRL;
                    if (i_byte_value inside {dle_pkg::CH_SOH, dle_pkg::CH_STX,
                                             dle_pkg::CH_ETX, dle_pkg::CH_EOT}) begin
                        n_index = '0;
                    end
                end
            end
            dle_pkg::FUNC_TX_DATA: begin
                o_push   = 1'b1;
                o_cmd.op = is_dle ? dle_pkg::OP_TX2 : dle_pkg::OP_TX1;
            end
            dle_pkg::FUNC_TX_CTRL: begin
                o_push   = 1'b1;
                o_cmd.op = is_dle ? dle_pkg::OP_TX3 : dle_pkg::OP_TX2;
            end
            default: begin
                o_push = 1'b0;
            end
        endcase
        if (!accept) begin
            o_push   = 1'b0;
            n_escape = r_escape;
            n_index  = r_index;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_auto_reply <= 1'b1;
            r_escape     <= 1'b0;
            r_index      <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_auto_reply <= i_cfg_wr_data;
            end
            r_escape <= n_escape;
            r_index  <= n_index;
        end
    end

endmodule

// ===== design/dle_queue.sv =====
module dle_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  dle_pkg::t_cmd     i_cmd,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_valid,
    output dle_pkg::t_cmd     o_cmd
);

    dle_pkg::t_cmd               r_mem [dle_pkg::Q_DEPTH];
    logic [dle_pkg::Q_PTR_W-1:0] r_wr_ptr;
    logic [dle_pkg::Q_PTR_W-1:0] r_rd_ptr;
    logic [dle_pkg::Q_CNT_W-1:0] r_count;
    logic                        do_pop;

    assign o_full  = (r_count == dle_pkg::Q_CNT_W'(dle_pkg::Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    function automatic logic [dle_pkg::Q_PTR_W-1:0] ptr_inc(
        input logic [dle_pkg::Q_PTR_W-1:0] p);
        logic [dle_pkg::Q_PTR_W-1:0] r;
        if (p == dle_pkg::Q_PTR_W'(dle_pkg::Q_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && do_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== design/dle_back.sv =====
module dle_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cmd_valid,
    input  dle_pkg::t_cmd              i_cmd,
    output logic                       o_pop,
    input  logic                       i_ready,
    output logic                       o_valid,
    output logic [1:0]                 o_kind,
    output logic [7:0]                 o_value,
    output logic [dle_pkg::POS_W-1:0]  o_position,
    output logic                       o_overflow,
    output logic                       o_last
);

    logic [1:0]                r_step;
    logic                      out_free;
    logic                      emit;
    logic [1:0]                s_kind;
    logic [7:0]                s_value;
    logic                      s_last;

    assign out_free = !o_valid || i_ready;
    assign emit     = out_free && i_cmd_valid;
    assign o_pop    = emit && s_last;

    always_comb begin
        s_kind  = dle_pkg::KIND_LINE;
        s_value = i_cmd.value;
        s_last  = 1'b1;
        case (i_cmd.op)
            dle_pkg::OP_DATA: begin
                s_kind = dle_pkg::KIND_DATA;
            end
            dle_pkg::OP_CTRL: begin
                s_kind = dle_pkg::KIND_CTRL;
            end
            dle_pkg::OP_CTRL_REPLY: begin
                if (r_step == 2'd0) begin
                    s_kind = dle_pkg::KIND_CTRL;
                    s_last = 1'b0;
                end else if (r_step == 2'd1) begin
                    s_value = dle_pkg::CH_DLE;
                    s_last  = 1'b0;
                end else begin
                    s_value = dle_pkg::reply_code(i_cmd.value);
                end
            end
            dle_pkg::OP_TX2: begin
                if (r_step == 2'd0) begin
                    s_value = dle_pkg::CH_DLE;
                    s_last  = 1'b0;
                end
            end
            dle_pkg::OP_TX3: begin
                if (r_step != 2'd2) begin
                    s_value = dle_pkg::CH_DLE;
                    s_last  = 1'b0;
                end
            end
            default: begin
                s_kind = dle_pkg::KIND_LINE;
            end
        endcase
    end

    // position and overflow only ever nonzero on data results
    always_ff @(posedge i_clk) begin
        if (emit) begin
            o_kind     <= s_kind;
            o_value    <= s_value;
            o_position <= (i_cmd.op == dle_pkg::OP_DATA) ? i_cmd.position : '0;
            o_overflow <= (i_cmd.op == dle_pkg::OP_DATA) ? i_cmd.overflow : 1'b0;
            o_last     <= s_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
            r_step  <= '0;
        end else begin
            if (out_free) begin
                o_valid <= i_cmd_valid;
            end
            if (emit) begin
                r_step <= s_last ? 2'd0 : r_step + 2'd1;
            end
        end
    end

endmodule

// ===== design/dle_transparent_link_framer.sv =====
// DLE byte-stuffing link framer.
// An input transaction is queued as one command; the back end expands it into its
// results in the output register. Throughput: one result per cycle while the output is
// not stalled; an input causes 1 to 3 results and may be taken while earlier results are
// still queued, as long as the queue is not full. Lone DLE and func 3 give no result.
// Reset (i_rst_n low, synchronous): escape flag and receive index cleared,
// auto_reply set to 1, command queue emptied, no output pending.
module dle_transparent_link_framer (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // configuration: auto_reply register
    input  logic                       i_cfg_wr_en,
    input  logic                       i_cfg_wr_data,
    // input channel
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [1:0]                 i_func,
    input  logic [7:0]                 i_byte_value,
    // result channel
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [1:0]                 o_kind,
    output logic [7:0]                 o_value,
    output logic [dle_pkg::POS_W-1:0]  o_position,
    output logic                       o_overflow,
    output logic                       o_last
);

    // Front end: destuffs receive bytes, tracks escape and block index,
    // and turns each input transaction, but a lone DLE or func 3, into one back-end command.
    logic          push;
    logic          q_full;
    dle_pkg::t_cmd push_cmd;

    // Queue to back end
    logic          head_valid;
    logic          pop;
    dle_pkg::t_cmd head_cmd;

    dle_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (i_in_valid),
        .i_func        (i_func),
        .i_byte_value  (i_byte_value),
        .i_q_full      (q_full),
        .o_ready       (o_in_ready),
        .o_push        (push),
        .o_cmd         (push_cmd)
    );

    // Two-entry queue decouples input stalls from output stalls.
    dle_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (head_valid),
        .o_cmd   (head_cmd)
    );

    // Back end: expands the head command into its 1..3 result transactions,
    // one per cycle while the output is not stalled, into the output register; pops on the last one.
    dle_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (head_valid),
        .i_cmd       (head_cmd),
        .o_pop       (pop),
        .i_ready     (i_out_ready),
        .o_valid     (o_out_valid),
        .o_kind      (o_kind),
        .o_value     (o_value),
        .o_position  (o_position),
        .o_overflow  (o_overflow),
        .o_last      (o_last)
    );

endmodule

// ===== tb/testbench.sv =====
module testbench;

    // func code 3 is not defined by the block; it must be dropped silently
    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DIR_ROWS = 25;

    // one result transaction as seen on the output channel
    typedef struct {
        logic [1:0]                kind;
        logic [7:0]                value;
        logic [dle_pkg::POS_W-1:0] position;
        logic                      overflow;
        logic                      last;
    } t_line_result;

    // directed row: the input transaction, plus an optional hand-typed result
    typedef struct {
        logic [1:0]   func;
        logic [7:0]   byte_v;
        bit           typed;
        t_line_result want;
    } t_stim_row;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_cfg_wr_en = 1'b0;
    logic                      i_cfg_wr_data = 1'b0;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_ready;
    logic [1:0]                i_func = 2'd0;
    logic [7:0]                i_byte_value = 8'h00;
    logic                      o_out_valid;
    logic                      i_out_ready = 1'b0;
    logic [1:0]                o_kind;
    logic [7:0]                o_value;
    logic [dle_pkg::POS_W-1:0] o_position;
    logic                      o_overflow;
    logic                      o_last;

    dle_transparent_link_framer i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_func        (i_func),
        .i_byte_value  (i_byte_value),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_kind        (o_kind),
        .o_value       (o_value),
        .o_position    (o_position),
        .o_overflow    (o_overflow),
        .o_last        (o_last)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Framer predictor: private copy of escape flag, receive index and
    // auto_reply. Each accepted input transaction fills step_out.
    // ------------------------------------------------------------------
    logic                      esc_armed;
    logic [dle_pkg::IDX_W-1:0] rx_count;
    logic                      auto_reply_mirror;
    t_line_result              step_out[$];
    t_line_result              awaited_line_results[$];

    // stimulus shaping, set by the sequencer, read by driver and receiver
    int  tx_idle_pct = 0;
    int  rx_stall_pct = 0;

    // bookkeeping
    int  err_count = 0;
    int  items_sent = 0;
    int  results_seen = 0;
    int  ctrl_seen = 0;
    int  ovf_seen = 0;
    int  cfg_writes = 0;
    int  quiet_cycles = 0;

    function automatic void emit_result(input logic [1:0] kind, input logic [7:0] value,
                                        input logic [dle_pkg::POS_W-1:0] pos,
                                        input logic ovf);
        t_line_result r;
        r.kind = kind;
        r.value = value;
        r.position = pos;
        r.overflow = ovf;
        r.last = 1'b0;
        step_out.push_back(r);
    endfunction

    // data byte into the current block; past the bound it is flagged and dropped
    function automatic void store_rx_byte(input logic [7:0] b);
        if (rx_count < dle_pkg::IDX_W'(dle_pkg::BLOCK_BYTES)) begin
            emit_result(dle_pkg::KIND_DATA, b, rx_count[dle_pkg::POS_W-1:0], 1'b0);
            rx_count = rx_count + 1'b1;
        end else begin
            emit_result(dle_pkg::KIND_DATA, b, '0, 1'b1);
        end
    endfunction

    function automatic void framer_predict(input logic [1:0] f, input logic [7:0] b);
        logic [7:0]   reply;
        t_line_result tail;
        step_out.delete();
        reply = 8'h00;
        case (f)
            dle_pkg::FUNC_RX: begin
                if (!esc_armed) begin
                    // lone DLE only arms the escape
                    if (b == dle_pkg::CH_DLE) esc_armed = 1'b1;
                    else store_rx_byte(b);
                end else begin
                    esc_armed = 1'b0;
                    if (b == dle_pkg::CH_DLE) begin
                        store_rx_byte(b);      // doubled DLE is data
                    end else begin
                        emit_result(dle_pkg::KIND_CTRL, b, '0, 1'b0);
                        if (b == dle_pkg::CH_SOH || b == dle_pkg::CH_STX) rx_count = '0;
                        if (auto_reply_mirror) begin
                            case (b)
                                dle_pkg::CH_ENQ: reply = dle_pkg::CH_ACK0;
                                dle_pkg::CH_ETB: reply = dle_pkg::CH_ACK1;
                                dle_pkg::CH_ETX: reply = dle_pkg::CH_EOT;
                                default:         reply = 8'h00;
                            endcase
                        end
                        if (reply != 8'h00) begin
                            emit_result(dle_pkg::KIND_LINE, dle_pkg::CH_DLE, '0, 1'b0);
                            emit_result(dle_pkg::KIND_LINE, reply, '0, 1'b0);
                        end
                        // session end, independent of auto_reply
                        if (b == dle_pkg::CH_ETX || b == dle_pkg::CH_EOT) begin
                            esc_armed = 1'b0;
                            rx_count = '0;
                        end
                    end
                end
            end
            dle_pkg::FUNC_TX_DATA: begin
                if (b == dle_pkg::CH_DLE)
                    emit_result(dle_pkg::KIND_LINE, dle_pkg::CH_DLE, '0, 1'b0);
                emit_result(dle_pkg::KIND_LINE, b, '0, 1'b0);
            end
            dle_pkg::FUNC_TX_CTRL: begin
                emit_result(dle_pkg::KIND_LINE, dle_pkg::CH_DLE, '0, 1'b0);
                if (b == dle_pkg::CH_DLE)
                    emit_result(dle_pkg::KIND_LINE, dle_pkg::CH_DLE, '0, 1'b0);
                emit_result(dle_pkg::KIND_LINE, b, '0, 1'b0);
            end
            default: ;
        endcase
        if (step_out.size() > 0) begin
            tail = step_out.pop_back();
            tail.last = 1'b1;
            step_out.push_back(tail);
        end
    endfunction

    // ------------------------------------------------------------------
    // Sender. Called at a rising edge; returns at the edge where the
    // transaction was accepted, with valid still high. Anything that
    // waits afterwards must drop valid first (see quiesce).
    // ------------------------------------------------------------------
    task automatic drive_item(input logic [1:0] f, input logic [7:0] b, input bit use_model);
        if ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < tx_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_func <= f;
        i_byte_value <= b;
        do @(posedge i_clk); while (!o_in_ready);
        framer_predict(f, b);
        if (use_model) begin
            foreach (step_out[k]) awaited_line_results.push_back(step_out[k]);
        end
        if (f != FUNC_UNUSED) items_sent++;
    endtask

    // drop valid, let every awaited result drain, then some slack cycles
    task automatic quiesce(input int slack);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (awaited_line_results.size() > 0) @(posedge i_clk);
        repeat (slack) @(posedge i_clk);
    endtask

    // config only while idle; slack covers a lone DLE still in flight
    task automatic write_auto_reply(input logic v);
        quiesce(4);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        auto_reply_mirror = v;
        cfg_writes++;
        i_cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [7:0] pick_ctrl();
        logic [7:0] c;
        case ($urandom_range(8))
            0: c = dle_pkg::CH_SOH;
            1: c = dle_pkg::CH_STX;
            2: c = dle_pkg::CH_ETX;
            3: c = dle_pkg::CH_EOT;
            4: c = dle_pkg::CH_ENQ;
            5: c = dle_pkg::CH_ACK0;
            6: c = dle_pkg::CH_ACK1;
            7: c = dle_pkg::CH_ETB;
            default: c = dle_pkg::CH_DLE;
        endcase
        return c;
    endfunction

    // bias toward the framing characters, keep full 8-bit coverage
    function automatic logic [7:0] pick_byte();
        logic [7:0] b;
        case ($urandom_range(3))
            0: b = dle_pkg::CH_DLE;
            1: b = pick_ctrl();
            default: b = 8'($urandom_range(255));
        endcase
        return b;
    endfunction

    // well-formed receive block: DLE SOH/STX, stuffed payload, DLE closer
    task automatic rx_block();
        logic [7:0] b;
        int         n;
        drive_item(dle_pkg::FUNC_RX, dle_pkg::CH_DLE, 1'b1);
        drive_item(dle_pkg::FUNC_RX, $urandom_range(1) ? dle_pkg::CH_STX : dle_pkg::CH_SOH,
                   1'b1);
        n = $urandom_range(8);
        repeat (n) begin
            b = pick_byte();
            if (b == dle_pkg::CH_DLE) drive_item(dle_pkg::FUNC_RX, dle_pkg::CH_DLE, 1'b1);
            drive_item(dle_pkg::FUNC_RX, b, 1'b1);
        end
        drive_item(dle_pkg::FUNC_RX, dle_pkg::CH_DLE, 1'b1);
        case ($urandom_range(5))
            0: b = dle_pkg::CH_ETB;
            1: b = dle_pkg::CH_ETX;
            2: b = dle_pkg::CH_ENQ;
            3: b = dle_pkg::CH_EOT;
            4: b = dle_pkg::CH_ACK0;
            default: b = dle_pkg::CH_ACK1;
        endcase
        drive_item(dle_pkg::FUNC_RX, b, 1'b1);
    endtask

    task automatic random_stretch(input int goal);
        int stop_at;
        int r;
        stop_at = items_sent + goal;
        while (items_sent < stop_at) begin
            r = $urandom_range(99);
            if (r < 45) rx_block();
            else if (r < 65) drive_item(dle_pkg::FUNC_TX_DATA, pick_byte(), 1'b1);
            else if (r < 80) drive_item(dle_pkg::FUNC_TX_CTRL, pick_byte(), 1'b1);
            else drive_item(2'($urandom_range(3)), pick_byte(), 1'b1);  // noise
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver, scoreboard and watchdog, all sampled at the rising edge.
    // ------------------------------------------------------------------
    t_line_result seen;

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= rx_stall_pct);

        if (o_out_valid && i_out_ready) begin
            results_seen++;
            if (awaited_line_results.size() == 0) begin
                $error("unexpected result: kind %0d value %h", o_kind, o_value);
                err_count++;
            end else begin
                seen = awaited_line_results.pop_front();
                if (o_kind !== seen.kind) begin
                    $error("kind: expected %0d, actual %0d", seen.kind, o_kind);
                    err_count++;
                end
                if (o_value !== seen.value) begin
                    $error("value: expected %h, actual %h", seen.value, o_value);
                    err_count++;
                end
                if (o_position !== seen.position) begin
                    $error("position: expected %0d, actual %0d", seen.position, o_position);
                    err_count++;
                end
                if (o_overflow !== seen.overflow) begin
                    $error("overflow: expected %0b, actual %0b", seen.overflow, o_overflow);
                    err_count++;
                end
                if (o_last !== seen.last) begin
                    $error("last: expected %0b, actual %0b", seen.last, o_last);
                    err_count++;
                end
                if (seen.kind == dle_pkg::KIND_CTRL) ctrl_seen++;
                if (seen.overflow) ovf_seen++;
            end
        end

        // watchdog: no transaction on either channel for too long
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired, %0d results still awaited",
                     awaited_line_results.size());
            $display("dle_transparent_link_framer: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    t_stim_row dir_table[DIR_ROWS];

    function automatic t_stim_row mk_row(input logic [1:0] f, input logic [7:0] b,
                                         input bit typed, input logic [1:0] kind,
                                         input logic [7:0] value,
                                         input logic [dle_pkg::POS_W-1:0] pos);
        t_stim_row r;
        r.func = f;
        r.byte_v = b;
        r.typed = typed;
        r.want.kind = kind;
        r.want.value = value;
        r.want.position = pos;
        r.want.overflow = 1'b0;
        r.want.last = 1'b1;
        return r;
    endfunction

    initial begin
        logic [7:0] b;

        // directed rows; typed ones carry a single obvious result
        dir_table[0]  = mk_row(dle_pkg::FUNC_RX, 8'h00, 1, dle_pkg::KIND_DATA, 8'h00, 10'd0);
        dir_table[1]  = mk_row(dle_pkg::FUNC_RX, 8'hFF, 1, dle_pkg::KIND_DATA, 8'hFF, 10'd1);
        dir_table[2]  = mk_row(dle_pkg::FUNC_RX, dle_pkg::CH_DLE, 0,
                               dle_pkg::KIND_LINE, 8'h00, 10'd0);
        dir_table[3]  = mk_row(dle_pkg::FUNC_RX, dle_pkg::CH_DLE, 1,
                               dle_pkg::KIND_DATA, dle_pkg::CH_DLE, 10'd2);
        dir_table[4]  = mk_row(dle_pkg::FUNC_TX_DATA, 8'h00, 1,
                               dle_pkg::KIND_LINE, 8'h00, 10'd0);
        dir_table[5]  = mk_row(dle_pkg::FUNC_TX_DATA, 8'hFF, 1,
                               dle_pkg::KIND_LINE, 8'hFF, 10'd0);
        dir_table[6]  = mk_row(dle_pkg::FUNC_TX_DATA, dle_pkg::CH_DLE, 0,
                               dle_pkg::KIND_LINE, 8'h00, 10'd0);
        dir_table[7]  = mk_row(dle_pkg::FUNC_TX_CTRL, dle_pkg::CH_STX, 0,
                               dle_pkg::KIND_LINE, 8'h00, 10'd0);
        dir_table[8]  = mk_row(dle_pkg::FUNC_TX_CTRL, dle_pkg::CH_DLE, 0,
                               dle_pkg::KIND_LINE, 8'h00, 10'd0);
        dir_table[9]  = mk_row(FUNC_UNUSED, 8'hAA, 0, dle_pkg::KIND_LINE, 8'h00, 10'd0);
        dir_table[10] = mk_row(dle_pkg::FUNC_RX, dle_pkg::CH_DLE, 0,
                               dle_pkg::KIND_LINE, 8'h00, 10'd0);
        dir_table[11] = mk_row(dle_pkg::FUNC_RX, dle_pkg::CH_ENQ, 0,
                               dle_pkg::KIND_LINE, 8'h00, 10'd0);
        dir_table[12] = mk_row(dle_pkg::FUNC_RX, dle_pkg::CH_DLE, 0,
                               dle_pkg::KIND_LINE, 8'h00, 10'd0);
        dir_table[13] = mk_row(dle_pkg::FUNC_RX, dle_pkg::CH_ETB, 0,
                               dle_pkg::KIND_LINE, 8'h00, 10'd0);
        dir_table[14] = mk_row(dle_pkg::FUNC_RX, dle_pkg::CH_DLE, 0,
                               dle_pkg::KIND_LINE, 8'h00, 10'd0);
        dir_table[15] = mk_row(dle_pkg::FUNC_RX, dle_pkg::CH_ACK0, 0,
                               dle_pkg::KIND_LINE, 8'h00, 10'd0);
        dir_table[16] = mk_row(dle_pkg::FUNC_RX, dle_pkg::CH_DLE, 0,
                               dle_pkg::KIND_LINE, 8'h00, 10'd0);
        dir_table[17] = mk_row(dle_pkg::FUNC_RX, dle_pkg::CH_SOH, 0,
                               dle_pkg::KIND_LINE, 8'h00, 10'd0);
        dir_table[18] = mk_row(dle_pkg::FUNC_RX, 8'h41, 1, dle_pkg::KIND_DATA, 8'h41, 10'd0);
        dir_table[19] = mk_row(dle_pkg::FUNC_RX, dle_pkg::CH_DLE, 0,
                               dle_pkg::KIND_LINE, 8'h00, 10'd0);
        dir_table[20] = mk_row(dle_pkg::FUNC_RX, dle_pkg::CH_ETX, 0,
                               dle_pkg::KIND_LINE, 8'h00, 10'd0);
        dir_table[21] = mk_row(dle_pkg::FUNC_RX, dle_pkg::CH_DLE, 0,
                               dle_pkg::KIND_LINE, 8'h00, 10'd0);
        dir_table[22] = mk_row(dle_pkg::FUNC_RX, dle_pkg::CH_EOT, 0,
                               dle_pkg::KIND_LINE, 8'h00, 10'd0);
        dir_table[23] = mk_row(dle_pkg::FUNC_RX, dle_pkg::CH_DLE, 0,
                               dle_pkg::KIND_LINE, 8'h00, 10'd0);
        dir_table[24] = mk_row(dle_pkg::FUNC_RX, 8'hFF, 0, dle_pkg::KIND_LINE, 8'h00, 10'd0);

        // predictor starts from the reset state
        esc_armed = 1'b0;
        rx_count = '0;
        auto_reply_mirror = 1'b1;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part, reset value of auto_reply (on)
        foreach (dir_table[i]) begin
            drive_item(dir_table[i].func, dir_table[i].byte_v, !dir_table[i].typed);
            if (dir_table[i].typed) awaited_line_results.push_back(dir_table[i].want);
        end

        // fill one block past its bound: last positions, then flagged drops
        quiesce(0);
        drive_item(dle_pkg::FUNC_RX, dle_pkg::CH_DLE, 1'b1);
        drive_item(dle_pkg::FUNC_RX, dle_pkg::CH_STX, 1'b1);
        repeat (dle_pkg::BLOCK_BYTES + 3) begin
            b = 8'($urandom_range(255));
            if (b == dle_pkg::CH_DLE) b = 8'hEF;
            drive_item(dle_pkg::FUNC_RX, b, 1'b1);
        end
        drive_item(dle_pkg::FUNC_RX, dle_pkg::CH_DLE, 1'b1);
        drive_item(dle_pkg::FUNC_RX, dle_pkg::CH_ETX, 1'b1);

        // random phases: each with its own idling and auto_reply setting,
        // and a full drain in the middle of every phase but the last
        write_auto_reply(1'b1);
        tx_idle_pct = 0;  rx_stall_pct = 0;
        random_stretch(37); quiesce(0); random_stretch(37);

        write_auto_reply(1'b0);
        tx_idle_pct = 74; rx_stall_pct = 0;
        random_stretch(37); quiesce(0); random_stretch(37);

        write_auto_reply(1'b1);
        tx_idle_pct = 0;  rx_stall_pct = 74;
        random_stretch(37); quiesce(0); random_stretch(37);

        write_auto_reply(1'b0);
        tx_idle_pct = 15; rx_stall_pct = 15;
        random_stretch(37); quiesce(0); random_stretch(37);

        write_auto_reply(1'b1);
        tx_idle_pct = 0;  rx_stall_pct = 0;
        random_stretch(37);

        // drain, then watch for stray results
        quiesce(8);

        $display("run: %0d input transactions, %0d results (%0d control events, %0d drops)",
                 items_sent, results_seen, ctrl_seen, ovf_seen);
        $display("run: %0d auto_reply writes across idle and stall phases, %0d errors",
                 cfg_writes, err_count);
        if (err_count == 0) begin
            $display("dle_transparent_link_framer: match");
        end else begin
            $display("dle_transparent_link_framer: mismatch");
        end
        $finish;
    end

endmodule
